FILE: sv/dwta_pkg.sv
// Shared constants and controller/datapath interface types for the disparity selector.
package dwta_pkg;

  localparam int MAX_LEVELS = 128;
  localparam int LEVEL_W    = $clog2(MAX_LEVELS);
  localparam int CNT_W      = $clog2(MAX_LEVELS + 1);

  localparam int COST_W = 8;
  localparam int NUM_W  = 8;
  localparam int DISP_W = 16;
  localparam int CONF_W = 8;
  localparam int FRAC_W = 8;

  localparam logic [COST_W-1:0] COST_MAX   = 8'hFF;
  localparam logic [NUM_W-1:0]  NUM_RESET  = 8'd128;

  // Shared restoring divider: 17-bit dividend, 11-bit divisor, one quotient bit per cycle.
  localparam int DIVN_W    = 17;
  localparam int DIVD_W    = 11;
  localparam int DIV_STEPS = DIVN_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic acc;            // take one cost beat
    logic div_load_conf;  // start confidence division from pixel snapshot
    logic div_load_disp;  // keep confidence, start subpixel division
    logic div_step;       // one restoring division step
    logic out_load;       // build result into output register
  } dwta_cmd_t;

  typedef struct packed {
    logic last_level;     // current cost beat closes the pixel
  } dwta_sts_t;

endpackage

FILE: sv/dwta_ctrl.sv
// Controller: sequences level accumulation, the two divisions and the output load.
module dwta_ctrl import dwta_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  dwta_sts_t sts_i,
  output dwta_cmd_t cmd_o
);

  localparam logic [2:0] ST_ACC  = 3'd0;
  localparam logic [2:0] ST_LDC  = 3'd1;
  localparam logic [2:0] ST_DIVC = 3'd2;
  localparam logic [2:0] ST_LDD  = 3'd3;
  localparam logic [2:0] ST_DIVD = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign in_stall_o  = (state_q != ST_ACC);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_ACC: begin
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (sts_i.last_level) state_d = ST_LDC;
        end
      end
      ST_LDC: begin
        cmd_o.div_load_conf = 1'b1;
        step_d  = '0;
        state_d = ST_DIVC;
      end
      ST_DIVC: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_LAST) state_d = ST_LDD;
      end
      ST_LDD: begin
        cmd_o.div_load_disp = 1'b1;
        step_d  = '0;
        state_d = ST_DIVD;
      end
      ST_DIVD: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: sv/dwta_dp.sv
// Datapath: per-pixel cost tracking, pixel snapshot, serial divider and result register.
module dwta_dp import dwta_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [NUM_W-1:0]  cfg_wdata_i,
  input  logic [COST_W-1:0] cost_i,
  input  dwta_cmd_t         cmd_i,
  output dwta_sts_t         sts_o,
  output logic [DISP_W-1:0] disparity_q8_o,
  output logic [CONF_W-1:0] confidence_o
);

  logic [NUM_W-1:0]   num_levels_q;
  logic [CNT_W-1:0]   n_eff;

  // Per-pixel tracking state.
  logic [CNT_W-1:0]   count_q, count_d;
  logic [COST_W-1:0]  low_q, low_d, sec_q, sec_d, thr_q, thr_d;
  logic [LEVEL_W-1:0] best_q, best_d, sec_lvl_q, sec_lvl_d;
  logic [COST_W-1:0]  prev_q, before_q, before_d, after_q, after_d;
  logic               pend_q, pend_d;
  logic [CNT_W:0]     cnt_inc;
  logic [LEVEL_W-1:0] lvl;
  logic               last;

  // Snapshot of the closed pixel.
  logic [LEVEL_W-1:0] s_best_q;
  logic [COST_W-1:0]  s_low_q, s_comp_q, s_before_q, s_after_q;
  logic               s_adj_q;
  logic               adj_d;
  logic [LEVEL_W:0]   best_ext, sec_ext;

  // Operand formation from the snapshot.
  logic signed [DIVD_W-1:0] den;
  logic                     den_pos;
  logic [COST_W-1:0]        mag, gap;
  logic                     neg;
  logic                     conf_ok;
  logic [DIVN_W-1:0]        conf_num, disp_num;

  // Divider.
  logic [DIVD_W-1:0] rem_q, dsr_q;
  logic [DIVN_W-1:0] quo_q;
  logic [DIVD_W:0]   rem_sh;
  logic              fits;

  logic              frac_q, neg_q;
  logic [CONF_W-1:0] conf_q;
  logic [DISP_W-1:0] base, qd, disp;

  // Saturate the level count register into the legal range.
  always_comb begin
    if (num_levels_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(num_levels_q) > MAX_LEVELS) begin
      n_eff = CNT_W'(MAX_LEVELS);
    end else begin
      n_eff = CNT_W'(num_levels_q);
    end
  end

  assign cnt_inc         = {1'b0, count_q} + (CNT_W+1)'(1);
  assign last            = cnt_inc >= {1'b0, n_eff};
  assign lvl             = count_q[LEVEL_W-1:0];
  assign sts_o.last_level = last;

  always_comb begin
    low_d     = low_q;
    sec_d     = sec_q;
    thr_d     = thr_q;
    best_d    = best_q;
    sec_lvl_d = sec_lvl_q;
    before_d  = before_q;
    after_d   = after_q;
    pend_d    = pend_q;
    count_d   = cnt_inc[CNT_W-1:0];
    if (cost_i < low_q) begin
      sec_lvl_d = best_q;
      best_d    = lvl;
      thr_d     = sec_q;
      sec_d     = low_q;
      low_d     = cost_i;
      before_d  = (count_q != '0) ? prev_q : COST_MAX;
      after_d   = COST_MAX;
      pend_d    = 1'b1;
    end else begin
      if (pend_q) begin
        after_d = cost_i;
        pend_d  = 1'b0;
      end
      if (cost_i < sec_q) begin
        sec_lvl_d = lvl;
        thr_d     = sec_q;
        sec_d     = cost_i;
      end else if (cost_i < thr_q) begin
        thr_d = cost_i;
      end
    end
  end

  // compare one bit wider so the top level never wraps onto level 0
  assign best_ext = {1'b0, best_d};
  assign sec_ext  = {1'b0, sec_lvl_d};
  assign adj_d    = (best_ext + (LEVEL_W+1)'(1) == sec_ext) ||
                    (sec_ext + (LEVEL_W+1)'(1) == best_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_levels_q <= NUM_RESET;
    end else if (cfg_we_i) begin
      num_levels_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      low_q     <= COST_MAX;
      sec_q     <= COST_MAX;
      thr_q     <= COST_MAX;
      best_q    <= '0;
      sec_lvl_q <= '0;
      prev_q    <= COST_MAX;
      before_q  <= COST_MAX;
      after_q   <= COST_MAX;
      pend_q    <= 1'b0;
    end else if (cmd_i.acc) begin
      if (last) begin
        // close the pixel and start the next one clean
        count_q   <= '0;
        low_q     <= COST_MAX;
        sec_q     <= COST_MAX;
        thr_q     <= COST_MAX;
        best_q    <= '0;
        sec_lvl_q <= '0;
        prev_q    <= COST_MAX;
        before_q  <= COST_MAX;
        after_q   <= COST_MAX;
        pend_q    <= 1'b0;
      end else begin
        count_q   <= count_d;
        low_q     <= low_d;
        sec_q     <= sec_d;
        thr_q     <= thr_d;
        best_q    <= best_d;
        sec_lvl_q <= sec_lvl_d;
        prev_q    <= cost_i;
        before_q  <= before_d;
        after_q   <= after_d;
        pend_q    <= pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && last) begin
      s_best_q   <= best_d;
      s_low_q    <= low_d;
      s_comp_q   <= adj_d ? thr_d : sec_d;
      s_before_q <= before_d;
      s_after_q  <= after_d;
      s_adj_q    <= adj_d;
    end
  end

  assign den = $signed({3'b000, s_before_q}) + $signed({3'b000, s_after_q})
             - $signed({2'b00, s_low_q, 1'b0});
  assign den_pos = !den[DIVD_W-1] && (den != '0);
  assign neg     = s_before_q < s_after_q;
  assign mag     = neg ? (s_after_q - s_before_q) : (s_before_q - s_after_q);
  // 2*128*|before-after| + den
  assign disp_num = {1'b0, mag, 8'b0} + DIVN_W'(den[DIVD_W-2:0]);

  assign conf_ok  = (s_comp_q != '0) && (s_comp_q >= s_low_q);
  assign gap      = s_comp_q - s_low_q;
  assign conf_num = {1'b0, gap, 8'b0} - DIVN_W'(gap);

  assign rem_sh = {rem_q, quo_q[DIVN_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load_conf) begin
      rem_q <= '0;
      quo_q <= conf_num;
      dsr_q <= DIVD_W'(s_comp_q);
    end else if (cmd_i.div_load_disp) begin
      rem_q <= '0;
      quo_q <= disp_num;
      dsr_q <= {den[DIVD_W-2:0], 1'b0};
    end else if (cmd_i.div_step) begin
      if (fits) begin
        rem_q <= DIVD_W'(rem_sh - {1'b0, dsr_q});
      end else begin
        rem_q <= rem_sh[DIVD_W-1:0];
      end
      quo_q <= {quo_q[DIVN_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load_disp) begin
      conf_q <= conf_ok ? quo_q[CONF_W-1:0] : '0;
      frac_q <= s_adj_q && den_pos;
      neg_q  <= neg;
    end
  end

  assign base = DISP_W'({s_best_q, {FRAC_W{1'b0}}});
  assign qd   = frac_q ? quo_q[DISP_W-1:0] : '0;
  // pull toward the side with the higher neighbor cost
  assign disp = neg_q ? (base + qd) : (base - qd);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      disparity_q8_o <= disp;
      confidence_o   <= conf_q;
    end
  end

endmodule

FILE: sv/disparity_winner_take_all.sv
// Winner-take-all disparity selector with parabolic subpixel refinement (top level).
//
// Usage:
// - cost_i carries one matching cost per beat on the in channel (in_valid_i /
//   in_stall_o), levels of one pixel in order, num_levels beats per pixel.
// - cfg_we_i / cfg_wdata_i write num_levels (0 acts as 1, values above 128 act
//   as 128); write it only while the block is idle.
// - One result per pixel leaves on the out channel (out_valid_o / out_stall_i):
//   disparity_q8_o in signed Q8 and confidence_o in 0..255.
// - Level beats are taken one per cycle while in_stall_o is low. After the
//   last level of a pixel the input stalls while one shared restoring divider
//   runs twice, 17 quotient bits each (confidence, then subpixel offset), with
//   a load step before each run; then the result enters the output register,
//   out_valid_o rises and the input is taken again.
// - A finished result waits in the output register while the next pixel's
//   levels are taken; if the receiver still stalls when the next pixel's
//   divisions finish, the input stalls until the output register is taken.
// - Reset sets num_levels to 128, clears the per-pixel state and drops out_valid_o.
module disparity_winner_take_all import dwta_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [NUM_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [COST_W-1:0] cost_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DISP_W-1:0] disparity_q8_o,
  output logic [CONF_W-1:0] confidence_o
);

  dwta_cmd_t cmd;
  dwta_sts_t sts;

  dwta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dwta_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cost_i         (cost_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .disparity_q8_o (disparity_q8_o),
    .confidence_o   (confidence_o)
  );

endmodule

FILE: sim/disparity_winner_take_all_test.sv
// Self-checking testbench for the winner-take-all disparity selector.
module disparity_winner_take_all_test;
  import dwta_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 48;
  localparam int STALL_LIMIT   = 3000;
  localparam int DIRECTED_ROWS = 26;
  localparam int PLAN_PHASES   = 10;

  typedef struct packed {
    logic [DISP_W-1:0] disp;
    logic [CONF_W-1:0] conf;
  } pixel_result_t;

  typedef enum logic {ROW_LEVELS, ROW_COST} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [7:0]        value;
    bit                typed;
    logic [DISP_W-1:0] disp;
    logic [CONF_W-1:0] conf;
  } stim_row_t;

  typedef struct {
    logic [NUM_W-1:0] levels;
    bit               pick;
    bit               squeeze;
    bit               quiet;
    int               beats;
  } phase_t;

  typedef enum int {
    PIX_VALLEY, PIX_NOISE, PIX_RAMP_DOWN, PIX_RAMP_UP, PIX_FLAT, PIX_TIES
  } pix_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [NUM_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [COST_W-1:0] cost_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [DISP_W-1:0] disparity_q8_o;
  logic [CONF_W-1:0] confidence_o;

  disparity_winner_take_all i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cost_i         (cost_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .disparity_q8_o (disparity_q8_o),
    .confidence_o   (confidence_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted pixel state, mirrored from the block's behavior
  logic [NUM_W-1:0]  levels_cfg;
  int                lvl_seen;
  logic [COST_W-1:0] low_cost, sec_cost, thr_cost;
  int                best_lvl, sec_lvl;
  logic [COST_W-1:0] prev_cost, before_cost, after_cost;
  bit                after_armed;

  pixel_result_t     pixel_results_due[$];
  logic [COST_W-1:0] pixel_costs[$];
  int unsigned       mismatches = 0;
  bit                calm = 1'b0;
  bit                hold_req = 1'b0;

  stim_row_t directed_rows [DIRECTED_ROWS];
  phase_t    phase_plan [PLAN_PHASES];

  function automatic int eff_levels(input logic [NUM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_LEVELS) return MAX_LEVELS;
    return int'(v);
  endfunction

  function automatic void clear_pixel_state();
    lvl_seen    = 0;
    low_cost    = COST_MAX;
    sec_cost    = COST_MAX;
    thr_cost    = COST_MAX;
    best_lvl    = 0;
    sec_lvl     = 0;
    prev_cost   = COST_MAX;
    before_cost = COST_MAX;
    after_cost  = COST_MAX;
    after_armed = 1'b0;
  endfunction

  function automatic logic [CONF_W-1:0] gap_conf(input int rival, input int best);
    if (rival == 0 || rival < best) return '0;
    return CONF_W'((255 * (rival - best)) / rival);
  endfunction

  // Take one cost level; return 1 with the pixel's result when the level closes it.
  function automatic bit wta_take_level(input logic [COST_W-1:0] c, output pixel_result_t r);
    int d, cu, cl, den, num, mag, q, disp;
    d = lvl_seen;
    r = '0;
    if (c < low_cost) begin
      sec_lvl     = best_lvl;
      best_lvl    = d;
      thr_cost    = sec_cost;
      sec_cost    = low_cost;
      low_cost    = c;
      before_cost = (d > 0) ? prev_cost : COST_MAX;
      after_cost  = COST_MAX;
      after_armed = 1'b1;
    end else begin
      if (after_armed) begin
        after_cost  = c;
        after_armed = 1'b0;
      end
      if (c < sec_cost) begin
        sec_lvl  = d;
        thr_cost = sec_cost;
        sec_cost = c;
      end else if (c < thr_cost) begin
        thr_cost = c;
      end
    end
    prev_cost = c;
    lvl_seen  = d + 1;
    if (lvl_seen < eff_levels(levels_cfg)) return 1'b0;

    disp = best_lvl * 256;
    if (best_lvl + 1 == sec_lvl || sec_lvl + 1 == best_lvl) begin
      cu  = int'(before_cost);
      cl  = int'(after_cost);
      den = cu + cl - 2 * int'(low_cost);
      if (den > 0) begin
        num  = 128 * (cu - cl);
        mag  = (num < 0) ? -num : num;
        // round half away from zero
        q    = (2 * mag + den) / (2 * den);
        disp = disp - ((num < 0) ? -q : q);
      end
      r.conf = gap_conf(int'(thr_cost), int'(low_cost));
    end else begin
      r.conf = gap_conf(int'(sec_cost), int'(low_cost));
    end
    r.disp = DISP_W'(disp);
    clear_pixel_state();
    return 1'b1;
  endfunction

  task automatic send_cost(input logic [COST_W-1:0] c, input bit typed,
                           input logic [DISP_W-1:0] td, input logic [CONF_W-1:0] tc);
    pixel_result_t r;
    cost_i     <= c;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (wta_take_level(c, r)) begin
      if (typed) begin
        r.disp = td;
        r.conf = tc;
      end
      pixel_results_due.push_back(r);
    end
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for all results, then let the last division settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pixel_results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_levels(input logic [NUM_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    levels_cfg  = v;
  endtask

  task automatic make_pixel(input int n, input pix_mode_e mode);
    int centre, valley_floor, lslope, rslope, flat_cost, base, v;
    centre       = $urandom_range(0, n - 1);
    valley_floor = $urandom_range(0, 200);
    lslope       = $urandom_range(1, 48);
    rslope       = $urandom_range(1, 48);
    flat_cost    = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(0, 255);
    base         = $urandom_range(0, 253);
    pixel_costs.delete();
    for (int i = 0; i < n; i++) begin
      case (mode)
        PIX_VALLEY: begin
          v = valley_floor + $urandom_range(0, 2) +
              ((i < centre) ? lslope * (centre - i) : rslope * (i - centre));
        end
        PIX_RAMP_DOWN: v = 255 - ((i + 1) * 255) / n;
        PIX_RAMP_UP:   v = (i * 255) / n;
        PIX_FLAT:      v = flat_cost;
        PIX_TIES:      v = base + $urandom_range(0, 2);
        default:       v = $urandom_range(0, 255);
      endcase
      pixel_costs.push_back(COST_W'((v > 255) ? 255 : v));
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    int burst;
    burst       = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        burst    = HOLD_CYCLES;
      end
      if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst       = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each result beat against the oldest prediction
  initial begin
    pixel_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pixel_results_due.size() == 0) begin
          $error("result with none expected: disparity_q8 %0d confidence %0d",
                 $signed(disparity_q8_o), confidence_o);
          mismatches++;
        end else begin
          want = pixel_results_due.pop_front();
          if (disparity_q8_o !== want.disp) begin
            $error("disparity_q8: expected %0d, got %0d",
                   $signed(want.disp), $signed(disparity_q8_o));
            mismatches++;
          end
          if (confidence_o !== want.conf) begin
            $error("confidence: expected %0d, got %0d", want.conf, confidence_o);
            mismatches++;
          end
        end
      end
    end
  end

  // End the run when neither channel moves for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [NUM_W-1:0] levels;
    int               sent;
    pix_mode_e        mode;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    cost_i      = '0;
    levels_cfg  = NUM_RESET;
    clear_pixel_state();

    directed_rows = '{
      '{ROW_LEVELS, 8'd1,   1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd0,   1'b1, 16'd0, 8'd255},
      '{ROW_COST,   8'd255, 1'b1, 16'd0, 8'd0},
      '{ROW_COST,   8'd254, 1'b1, 16'd0, 8'd1},
      '{ROW_LEVELS, 8'd0,   1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd100, 1'b1, 16'd0, 8'd155},
      '{ROW_LEVELS, 8'd2,   1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd10,  1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd20,  1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd20,  1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd10,  1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd0,   1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd0,   1'b0, 16'd0, 8'd0},
      '{ROW_LEVELS, 8'd3,   1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd0,   1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd9,   1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd0,   1'b1, 16'd0, 8'd0},
      '{ROW_COST,   8'd255, 1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd255, 1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd255, 1'b1, 16'd0, 8'd0},
      '{ROW_COST,   8'd200, 1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd100, 1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd50,  1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd40,  1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd30,  1'b0, 16'd0, 8'd0},
      '{ROW_COST,   8'd90,  1'b0, 16'd0, 8'd0}
    };

    phase_plan = '{
      '{8'd1,   1'b0, 1'b0, 1'b0, 200},
      '{8'd0,   1'b0, 1'b0, 1'b0, 150},
      '{8'd2,   1'b0, 1'b0, 1'b0, 220},
      '{8'd3,   1'b0, 1'b0, 1'b0, 210},
      '{8'd0,   1'b1, 1'b0, 1'b0, 220},
      '{8'd255, 1'b0, 1'b0, 1'b0, 128},
      '{8'd2,   1'b0, 1'b1, 1'b0, 200},
      '{8'd0,   1'b1, 1'b0, 1'b0, 220},
      '{8'd128, 1'b0, 1'b0, 1'b0, 256},
      '{8'd5,   1'b0, 1'b0, 1'b1, 200}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One full pixel at the reset level count, best cost on the last level
    make_pixel(eff_levels(levels_cfg), PIX_RAMP_DOWN);
    foreach (pixel_costs[i]) send_cost(pixel_costs[i], 1'b0, '0, '0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_LEVELS) begin
        wait_idle();
        write_levels(directed_rows[i].value);
      end else begin
        send_cost(directed_rows[i].value, directed_rows[i].typed,
                  directed_rows[i].disp, directed_rows[i].conf);
      end
    end

    foreach (phase_plan[p]) begin
      wait_idle();
      levels = phase_plan[p].pick ? NUM_W'($urandom_range(4, 40)) : phase_plan[p].levels;
      write_levels(levels);
      calm = phase_plan[p].quiet;
      if (phase_plan[p].squeeze) hold_req = 1'b1;
      sent = 0;
      while (sent < phase_plan[p].beats) begin
        mode = ($urandom_range(0, 1) == 0) ? PIX_VALLEY
                                           : pix_mode_e'($urandom_range(0, 5));
        make_pixel(eff_levels(levels), mode);
        foreach (pixel_costs[i]) send_cost(pixel_costs[i], 1'b0, '0, '0);
        sent += pixel_costs.size();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
